/* hdl/box_mean_3x3_max_locate_macros.svh */
// Assertion macros shared by the checker of the 3x3 box-mean maximum locator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BOX_MEAN_3X3_MAX_LOCATE_MACROS_SVH
`define BOX_MEAN_3X3_MAX_LOCATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMML_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bmml_pkg.sv */
// Shared constants, types and the exact mean comparison of the 3x3 box-mean
// maximum locator. No dependencies.
package bmml_pkg;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;
  localparam logic [CFG_W-1:0]     FRAME_DIM_RST  = 11'd2;

  // Default sizes.
  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Stream words.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_SUM_W  = 20;
  localparam int OUT_CNT_W  = 4;
  localparam int OUT_POS_W  = 10;
  localparam int OUT_PAD_W  = 4;
  localparam int OUT_DATA_W = OUT_SUM_W + OUT_CNT_W + 2 * OUT_POS_W + OUT_PAD_W;

  // Neighborhood sizes.
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_CORNER = 4'd4;
  localparam logic [CNT_W-1:0] CNT_EDGE   = 4'd6;
  localparam logic [CNT_W-1:0] CNT_INNER  = 4'd9;

  // Comparison widths cover the largest sample width.
  localparam int CMP_SUM_W  = 36;
  localparam int CMP_PROD_W = CMP_SUM_W + CNT_W;

  typedef struct packed {
    logic en;     // pipeline advances
    logic clear;  // drop the partial frame
  } trk_ctrl_t;

  // True when a_sum/a_cnt is strictly greater than b_sum/b_cnt.
  function automatic logic mean_gt(input logic [CMP_SUM_W-1:0] a_sum,
                                   input logic [CNT_W-1:0]     a_cnt,
                                   input logic [CMP_SUM_W-1:0] b_sum,
                                   input logic [CNT_W-1:0]     b_cnt);
    logic [CMP_PROD_W-1:0] lhs;
    logic [CMP_PROD_W-1:0] rhs;
    lhs = CMP_PROD_W'(a_sum) * CMP_PROD_W'(b_cnt);
    rhs = CMP_PROD_W'(b_sum) * CMP_PROD_W'(a_cnt);
    return lhs > rhs;
  endfunction

endpackage

/* hdl/bmml_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module bmml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bmml_track.sv */
// Running maximum of neighborhood means over one frame, fed two candidates
// per cycle in raster order while ctrl.en is high. Depends on bmml_pkg.
module bmml_track #(
  parameter int SUM_W = 20,
  parameter int ROW_W = 10,
  parameter int COL_W = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bmml_pkg::trk_ctrl_t      ctrl,
  input  logic                     a_valid,
  input  logic [SUM_W-1:0]         a_sum,
  input  logic [bmml_pkg::CNT_W-1:0] a_cnt,
  input  logic [ROW_W-1:0]         a_row,
  input  logic [COL_W-1:0]         a_col,
  input  logic                     b_valid,
  input  logic [SUM_W-1:0]         b_sum,
  input  logic [bmml_pkg::CNT_W-1:0] b_cnt,
  input  logic [ROW_W-1:0]         b_row,
  input  logic [COL_W-1:0]         b_col,
  input  logic                     frame_end,
  output logic                     fin_valid,
  output logic [SUM_W-1:0]         fin_sum,
  output logic [bmml_pkg::CNT_W-1:0] fin_cnt,
  output logic [ROW_W-1:0]         fin_row,
  output logic [COL_W-1:0]         fin_col
);
  import bmml_pkg::*;

  // Input register.
  logic             ca_valid, cb_valid, c_end;
  logic [SUM_W-1:0] ca_sum, cb_sum;
  logic [CNT_W-1:0] ca_cnt, cb_cnt;
  logic [ROW_W-1:0] ca_row, cb_row;
  logic [COL_W-1:0] ca_col, cb_col;

  // Better of the pair.
  logic             pk_valid, pk_end;
  logic [SUM_W-1:0] pk_sum;
  logic [CNT_W-1:0] pk_cnt;
  logic [ROW_W-1:0] pk_row;
  logic [COL_W-1:0] pk_col;

  // Running maximum.
  logic             empty;
  logic [SUM_W-1:0] best_sum, best_sum_next;
  logic [CNT_W-1:0] best_cnt, best_cnt_next;
  logic [ROW_W-1:0] best_row, best_row_next;
  logic [COL_W-1:0] best_col, best_col_next;

  logic take_b;
  logic upd;

  // The later candidate wins only when strictly greater.
  assign take_b = cb_valid &&
                  (!ca_valid || mean_gt(CMP_SUM_W'(cb_sum), cb_cnt,
                                        CMP_SUM_W'(ca_sum), ca_cnt));

  assign upd = pk_valid &&
               (empty || mean_gt(CMP_SUM_W'(pk_sum), pk_cnt,
                                 CMP_SUM_W'(best_sum), best_cnt));

  always_comb begin
    best_sum_next = upd ? pk_sum : best_sum;
    best_cnt_next = upd ? pk_cnt : best_cnt;
    best_row_next = upd ? pk_row : best_row;
    best_col_next = upd ? pk_col : best_col;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      ca_valid  <= 1'b0;
      cb_valid  <= 1'b0;
      c_end     <= 1'b0;
      pk_valid  <= 1'b0;
      pk_end    <= 1'b0;
      fin_valid <= 1'b0;
      empty     <= 1'b1;
    end else if (ctrl.en) begin
      ca_valid  <= a_valid;
      cb_valid  <= b_valid;
      c_end     <= frame_end;
      pk_valid  <= ca_valid || cb_valid;
      pk_end    <= c_end;
      fin_valid <= pk_end;
      empty     <= pk_end || (empty && !pk_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      ca_sum <= a_sum;
      ca_cnt <= a_cnt;
      ca_row <= a_row;
      ca_col <= a_col;
      cb_sum <= b_sum;
      cb_cnt <= b_cnt;
      cb_row <= b_row;
      cb_col <= b_col;
      pk_sum <= take_b ? cb_sum : ca_sum;
      pk_cnt <= take_b ? cb_cnt : ca_cnt;
      pk_row <= take_b ? cb_row : ca_row;
      pk_col <= take_b ? cb_col : ca_col;
      best_sum <= best_sum_next;
      best_cnt <= best_cnt_next;
      best_row <= best_row_next;
      best_col <= best_col_next;
      if (pk_end) begin
        fin_sum <= best_sum_next;
        fin_cnt <= best_cnt_next;
        fin_row <= best_row_next;
        fin_col <= best_col_next;
      end
    end
  end

endmodule

/* hdl/box_mean_3x3_max_locate.sv */
// Top level of the 3x3 box-mean maximum locator.
// Depends on bmml_pkg, bmml_ram and bmml_track.
//
// Usage:
//   Samples arrive on the s_* stream in raster order, one word per sample.
//   frame_rows and frame_cols are set through cfg_we/cfg_index/cfg_data while
//   the block is idle; any write also drops a partial frame. Values outside
//   2..MAX_ROWS and 2..MAX_COLS are clamped.
//   After the last sample of a frame one word leaves on m_*: the neighborhood
//   sum and size (4, 6 or 9) of the largest 3x3 mean and the row and column
//   of its first occurrence in raster order.
// Throughput: one sample per clock unless stalled. The line buffer RAM takes
//   one read and one write per cycle, and each sample feeds a fixed pipeline.
// Result path: stages 1 and 2, the tracker registers, the output register.
// Reset: rst clears position, running maxima and the output register;
//   frame_rows and frame_cols return to 2.
// Stall: a result may wait on m_tready while samples keep flowing; the
//   pipeline halts only when a second result is ready for the output register
//   while the first is still held.
module box_mean_3x3_max_locate #(
  parameter int MAX_COLS    = bmml_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = bmml_pkg::DEF_MAX_ROWS,
  parameter int SAMPLE_BITS = bmml_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bmml_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [19:0] best_sum, [23:20] best_count, [33:24] best_row, [43:34] best_col
  output logic [bmml_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [bmml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmml_pkg::CFG_W-1:0]      cfg_data
);
  import bmml_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int SB    = SAMPLE_BITS;
  localparam int CS_W  = SAMPLE_BITS + 2;
  localparam int SUM_W = SAMPLE_BITS + 4;
  localparam int IN_W  = (SAMPLE_BITS < IN_DATA_W) ? SAMPLE_BITS : IN_DATA_W;

  logic [CFG_W-1:0] frame_rows, frame_cols;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;

  logic adv;
  logic accept;
  logic fin_valid;

  // Stage 1: sample with its position; line buffer data arrives here.
  logic          s1_valid;
  logic [SB-1:0] s1_sample;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic          s1_last_row, s1_last_col;
  logic [2*SB-1:0] ram_rdata;
  logic [SB-1:0] up1, up2;
  logic [CS_W-1:0] cs_mid, cs_last;

  // Stage 2: column sums and the two-column history of each row band.
  logic            s2_valid;
  logic [CS_W-1:0] s2_cs_mid, s2_cs_last;
  logic [ROW_W-1:0] s2_row;
  logic [COL_W-1:0] s2_col;
  logic            s2_last_row, s2_last_col;
  logic [CS_W-1:0] mprev1, mprev2, lprev1, lprev2;

  logic             rc3, cc3;
  logic             mid_a_valid, mid_b_valid, last_a_valid, last_b_valid, frame_end;
  logic [SUM_W-1:0] mid_a_sum, mid_b_sum, last_a_sum, last_b_sum;
  logic [CNT_W-1:0] mid_a_cnt, mid_b_cnt, last_a_cnt, last_b_cnt;
  logic [ROW_W-1:0] mid_row;
  logic [COL_W-1:0] prev_col;

  trk_ctrl_t trk_ctrl;

  logic             mr_fin_valid, lr_fin_valid;
  logic [SUM_W-1:0] mr_sum, lr_sum;
  logic [CNT_W-1:0] mr_cnt, lr_cnt;
  logic [ROW_W-1:0] mr_row, lr_row;
  logic [COL_W-1:0] mr_col, lr_col;
  logic             pick_last;

  logic [SUM_W-1:0] out_sum;
  logic [CNT_W-1:0] out_cnt;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  // Clamped frame size, kept as the index of the last row and column.
  always_comb begin
    if (frame_rows < CFG_W'(2)) begin
      last_row = ROW_W'(1);
    end else if (32'(frame_rows) > 32'(MAX_ROWS)) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(frame_rows - CFG_W'(1));
    end
    if (frame_cols < CFG_W'(2)) begin
      last_col = COL_W'(1);
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(frame_cols - CFG_W'(1));
    end
  end

  assign fin_valid = mr_fin_valid && lr_fin_valid;
  assign adv       = !(fin_valid && m_tvalid && !m_tready);
  assign s_tready  = adv;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= FRAME_DIM_RST;
      frame_cols <= FRAME_DIM_RST;
      row_cnt    <= '0;
      col_cnt    <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_ROWS) begin
        frame_rows <= cfg_data;
      end
      if (cfg_index == REG_FRAME_COLS) begin
        frame_cols <= cfg_data;
      end
      row_cnt  <= '0;
      col_cnt  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (col_cnt == last_col) begin
          col_cnt <= '0;
          row_cnt <= (row_cnt == last_row) ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + COL_W'(1);
        end
      end
      if (adv) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
      end
    end
  end

  // Line buffer: the low half holds the row above, the high half two rows up.
  bmml_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (adv && s1_valid),
    .waddr (s1_col),
    .wdata ({up1, s1_sample}),
    .re    (adv),
    .raddr (col_cnt),
    .rdata (ram_rdata)
  );

  assign up1 = ram_rdata[SB-1:0];
  assign up2 = ram_rdata[2*SB-1:SB];

  // Column sums for the row above the current one, and for the current row
  // when it closes the frame. Two rows up exists only from row 2 on.
  always_comb begin
    cs_mid  = ((s1_row > ROW_W'(1)) ? CS_W'(up2) : CS_W'(0)) + CS_W'(up1) + CS_W'(s1_sample);
    cs_last = CS_W'(up1) + CS_W'(s1_sample);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample   <= SB'(s_tdata[IN_W-1:0]);
      s1_row      <= row_cnt;
      s1_col      <= col_cnt;
      s1_last_row <= (row_cnt == last_row);
      s1_last_col <= (col_cnt == last_col);
      s2_cs_mid   <= cs_mid;
      s2_cs_last  <= cs_last;
      s2_row      <= s1_row;
      s2_col      <= s1_col;
      s2_last_row <= s1_last_row;
      s2_last_col <= s1_last_col;
      if (s2_valid) begin
        mprev2 <= mprev1;
        mprev1 <= s2_cs_mid;
        lprev2 <= lprev1;
        lprev1 <= s2_cs_last;
      end
    end
  end

  // A word at column c completes the cell at c-1; at the end of a row it also
  // completes the cell at c. rc3/cc3 say the neighborhood has three rows/cols.
  always_comb begin
    rc3      = s2_row > ROW_W'(1);
    cc3      = s2_col > COL_W'(1);
    mid_row  = s2_row - ROW_W'(1);
    prev_col = s2_col - COL_W'(1);

    mid_a_valid  = s2_valid && (s2_row != '0) && (s2_col != '0);
    mid_b_valid  = s2_valid && (s2_row != '0) && s2_last_col;
    last_a_valid = s2_valid && s2_last_row && (s2_col != '0);
    last_b_valid = s2_valid && s2_last_row && s2_last_col;
    frame_end    = last_b_valid;

    mid_a_sum  = (cc3 ? SUM_W'(mprev2) : SUM_W'(0)) + SUM_W'(mprev1) + SUM_W'(s2_cs_mid);
    mid_b_sum  = SUM_W'(mprev1) + SUM_W'(s2_cs_mid);
    last_a_sum = (cc3 ? SUM_W'(lprev2) : SUM_W'(0)) + SUM_W'(lprev1) + SUM_W'(s2_cs_last);
    last_b_sum = SUM_W'(lprev1) + SUM_W'(s2_cs_last);

    case ({rc3, cc3})
      2'b11:   mid_a_cnt = CNT_INNER;
      2'b10:   mid_a_cnt = CNT_EDGE;
      2'b01:   mid_a_cnt = CNT_EDGE;
      default: mid_a_cnt = CNT_CORNER;
    endcase
    mid_b_cnt  = rc3 ? CNT_EDGE : CNT_CORNER;
    last_a_cnt = cc3 ? CNT_EDGE : CNT_CORNER;
    last_b_cnt = CNT_CORNER;
  end

  assign trk_ctrl.en    = adv;
  assign trk_ctrl.clear = cfg_we;

  // Rows above the last one.
  bmml_track #(
    .SUM_W (SUM_W),
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_mid_track (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (trk_ctrl),
    .a_valid   (mid_a_valid),
    .a_sum     (mid_a_sum),
    .a_cnt     (mid_a_cnt),
    .a_row     (mid_row),
    .a_col     (prev_col),
    .b_valid   (mid_b_valid),
    .b_sum     (mid_b_sum),
    .b_cnt     (mid_b_cnt),
    .b_row     (mid_row),
    .b_col     (s2_col),
    .frame_end (frame_end),
    .fin_valid (mr_fin_valid),
    .fin_sum   (mr_sum),
    .fin_cnt   (mr_cnt),
    .fin_row   (mr_row),
    .fin_col   (mr_col)
  );

  // The last row, which follows all other rows in raster order.
  bmml_track #(
    .SUM_W (SUM_W),
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_last_track (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (trk_ctrl),
    .a_valid   (last_a_valid),
    .a_sum     (last_a_sum),
    .a_cnt     (last_a_cnt),
    .a_row     (s2_row),
    .a_col     (prev_col),
    .b_valid   (last_b_valid),
    .b_sum     (last_b_sum),
    .b_cnt     (last_b_cnt),
    .b_row     (s2_row),
    .b_col     (s2_col),
    .frame_end (frame_end),
    .fin_valid (lr_fin_valid),
    .fin_sum   (lr_sum),
    .fin_cnt   (lr_cnt),
    .fin_row   (lr_row),
    .fin_col   (lr_col)
  );

  assign pick_last = mean_gt(CMP_SUM_W'(lr_sum), lr_cnt, CMP_SUM_W'(mr_sum), mr_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_valid && adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && adv) begin
      out_sum <= pick_last ? lr_sum : mr_sum;
      out_cnt <= pick_last ? lr_cnt : mr_cnt;
      out_row <= pick_last ? lr_row : mr_row;
      out_col <= pick_last ? lr_col : mr_col;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, OUT_POS_W'(out_col), OUT_POS_W'(out_row),
                    OUT_CNT_W'(out_cnt), OUT_SUM_W'(out_sum)};

endmodule

/* hdl/bmml_checker.sv */
// Port-level checks for the 3x3 box-mean maximum locator, bound to its top.
// Depends on bmml_pkg and box_mean_3x3_max_locate_macros.svh.
`include "box_mean_3x3_max_locate_macros.svh"

module bmml_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bmml_pkg::OUT_DATA_W-1:0] m_tdata
);
  import bmml_pkg::*;

  logic [CNT_W-1:0] out_cnt;
  logic             in_busy;

  assign out_cnt = m_tdata[OUT_SUM_W +: CNT_W];
  // Input is only refused while a result sits unread on the output.
  assign in_busy = s_tvalid && !s_tready;

  `BMML_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
  `BMML_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result word changed while stalled")
  `BMML_ASSERT_SAME(a_in_stall, !s_tready || in_busy, m_tvalid && !m_tready, "input refused without output stall")
  `BMML_ASSERT_SAME(a_cnt_legal, m_tvalid, out_cnt == CNT_CORNER || out_cnt == CNT_EDGE || out_cnt == CNT_INNER, "illegal neighborhood size")

endmodule

bind box_mean_3x3_max_locate bmml_checker u_bmml_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
